/* design/ccfe_pkg.sv */
package ccfe_pkg;

  typedef logic [1:0] opcode_t;
  typedef logic [2:0] field_sel_t;
  typedef logic [7:0] value_t;

  // Item codes
  localparam opcode_t OP_LOAD   = 2'd0;
  localparam opcode_t OP_UP     = 2'd1;
  localparam opcode_t OP_DOWN   = 2'd2;
  localparam opcode_t OP_SELECT = 2'd3;

  // Cursor positions, in the order the select button walks them
  localparam field_sel_t FLD_HOUR    = 3'd0;
  localparam field_sel_t FLD_MINUTE  = 3'd1;
  localparam field_sel_t FLD_SECOND  = 3'd2;
  localparam field_sel_t FLD_DATE    = 3'd3;
  localparam field_sel_t FLD_MONTH   = 3'd4;
  localparam field_sel_t FLD_YEAR    = 3'd5;
  localparam field_sel_t FLD_WEEKDAY = 3'd6;

  localparam value_t HOUR_MASK    = 8'h1F;
  localparam value_t HOUR_TOP     = 8'd12;
  localparam value_t MINSEC_TOP   = 8'd59;
  localparam value_t MONTH_TOP    = 8'd12;
  localparam value_t YEAR_TOP     = 8'd99;
  localparam value_t DATE_TOP     = 8'd31;
  localparam value_t DATE_TOP_SHORT = 8'd30;
  localparam value_t WEEKDAY_TOP  = 8'd7;

  // Packed BCD to binary, no digit checks, wraps to eight bits.
  function automatic value_t from_bcd(input value_t b);
    value_t hi;
    hi = {4'd0, b[7:4]};
    return value_t'((hi << 3) + (hi << 1) + {4'd0, b[3:0]});
  endfunction

  // Binary to packed BCD. Divide by ten is a multiply by 205 and a shift,
  // exact over the whole eight-bit range; the tens digit is cut to 4 bits.
  function automatic value_t to_bcd(input value_t v);
    logic [18:0] prod;
    logic [4:0]  q;
    value_t      rem;
    prod = 19'(v) * 19'd205;
    q    = prod[15:11];
    rem  = v - value_t'(8'(q) * 8'd10);
    return {q[3:0], rem[3:0]};
  endfunction

endpackage

/* design/clock_calendar_field_editor_top.sv */
// Clock and calendar field editor. Each transfer on the input channel is one
// button event (up, down, select) or a load of seven packed-BCD clock bytes,
// and each produces exactly one result transfer carrying all seven fields
// re-encoded as packed BCD, the cursor position after the event and a commit
// flag that is set only on the select that wraps the cursor back to the hour
// field. For an accepted event the field registers are updated and the
// result register is loaded at the same clock edge, so a new event can be
// taken every cycle unless the result register holds it back. The only
// thing that holds the input back is a full result register that the
// consumer is not taking in the same cycle.
module clock_calendar_field_editor_top (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  ccfe_pkg::opcode_t    opcode,
  input  ccfe_pkg::value_t     load_second,
  input  ccfe_pkg::value_t     load_minute,
  input  ccfe_pkg::value_t     load_hour,
  input  ccfe_pkg::value_t     load_weekday,
  input  ccfe_pkg::value_t     load_date,
  input  ccfe_pkg::value_t     load_month,
  input  ccfe_pkg::value_t     load_year,
  output logic                 out_valid,
  input  logic                 out_ready,
  output ccfe_pkg::value_t     out_second,
  output ccfe_pkg::value_t     out_minute,
  output ccfe_pkg::value_t     out_hour,
  output ccfe_pkg::value_t     out_weekday,
  output ccfe_pkg::value_t     out_date,
  output ccfe_pkg::value_t     out_month,
  output ccfe_pkg::value_t     out_year,
  output ccfe_pkg::field_sel_t selected_field,
  output logic                 committed
);
  import ccfe_pkg::*;

  // Field values are held in binary; they are only converted to BCD on the
  // way into the result register.
  value_t     second_value, minute_value, hour_value, weekday_value;
  value_t     date_value, month_value, year_value;
  field_sel_t cursor;

  value_t     second_value_next, minute_value_next, hour_value_next;
  value_t     weekday_value_next, date_value_next, month_value_next;
  value_t     year_value_next;
  field_sel_t cursor_next;
  logic       commit_next;
  logic       in_fire;
  logic       short_month;
  value_t     date_top;

  function automatic value_t step_up(input value_t v, input value_t top,
                                     input value_t bottom);
    value_t inc;
    inc = v + 8'd1;
    return (inc > top) ? bottom : inc;
  endfunction

  // Fields whose range starts at one fold anything at or below one to the top.
  function automatic value_t step_down_one(input value_t v, input value_t top);
    return (v <= 8'd1) ? top : v - 8'd1;
  endfunction

  function automatic value_t step_down_zero(input value_t v, input value_t top);
    return (v == 8'd0) ? top : v - 8'd1;
  endfunction

  // The result register can take a new transfer when it is empty or is being
  // emptied in this same cycle.
  assign in_ready = !out_valid || out_ready;
  assign in_fire  = in_valid && in_ready;

  // April, June, September and November have thirty days; February is
  // deliberately treated as a long month.
  assign short_month = (month_value == 8'd4) || (month_value == 8'd6) ||
                       (month_value == 8'd9) || (month_value == 8'd11);
  assign date_top    = short_month ? DATE_TOP_SHORT : DATE_TOP;

  always_comb begin
    second_value_next  = second_value;
    minute_value_next  = minute_value;
    hour_value_next    = hour_value;
    weekday_value_next = weekday_value;
    date_value_next    = date_value;
    month_value_next   = month_value;
    year_value_next    = year_value;
    cursor_next        = cursor;
    commit_next        = 1'b0;
    unique case (opcode)
      OP_LOAD: begin
        second_value_next  = from_bcd(load_second);
        minute_value_next  = from_bcd(load_minute);
        hour_value_next    = from_bcd(load_hour & HOUR_MASK);
        weekday_value_next = from_bcd(load_weekday);
        date_value_next    = from_bcd(load_date);
        month_value_next   = from_bcd(load_month);
        year_value_next    = from_bcd(load_year);
      end
      OP_UP: begin
        unique case (cursor)
          FLD_HOUR:    hour_value_next    = step_up(hour_value, HOUR_TOP, 8'd1);
          FLD_MINUTE:  minute_value_next  = step_up(minute_value, MINSEC_TOP, 8'd0);
          FLD_SECOND:  second_value_next  = step_up(second_value, MINSEC_TOP, 8'd0);
          FLD_DATE:    date_value_next    = step_up(date_value, date_top, 8'd1);
          FLD_MONTH:   month_value_next   = step_up(month_value, MONTH_TOP, 8'd1);
          FLD_YEAR:    year_value_next    = step_up(year_value, YEAR_TOP, 8'd0);
          FLD_WEEKDAY: weekday_value_next = step_up(weekday_value, WEEKDAY_TOP, 8'd1);
          default: begin
          end
        endcase
      end
      OP_DOWN: begin
        unique case (cursor)
          FLD_HOUR:    hour_value_next    = step_down_one(hour_value, HOUR_TOP);
          FLD_MINUTE:  minute_value_next  = step_down_zero(minute_value, MINSEC_TOP);
          FLD_SECOND:  second_value_next  = step_down_zero(second_value, MINSEC_TOP);
          FLD_DATE:    date_value_next    = step_down_one(date_value, date_top);
          FLD_MONTH:   month_value_next   = step_down_one(month_value, MONTH_TOP);
          FLD_YEAR:    year_value_next    = step_down_zero(year_value, YEAR_TOP);
          FLD_WEEKDAY: weekday_value_next = step_down_one(weekday_value, WEEKDAY_TOP);
          default: begin
          end
        endcase
      end
      OP_SELECT: begin
        // Stepping past the weekday (or from the unused code) wraps to the
        // hour and marks the edit as finished.
        if (cursor >= FLD_WEEKDAY) begin
          cursor_next = FLD_HOUR;
          commit_next = 1'b1;
        end else begin
          cursor_next = cursor + 3'd1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      second_value  <= '0;
      minute_value  <= '0;
      hour_value    <= '0;
      weekday_value <= '0;
      date_value    <= '0;
      month_value   <= '0;
      year_value    <= '0;
      cursor        <= FLD_HOUR;
    end else if (in_fire) begin
      second_value  <= second_value_next;
      minute_value  <= minute_value_next;
      hour_value    <= hour_value_next;
      weekday_value <= weekday_value_next;
      date_value    <= date_value_next;
      month_value   <= month_value_next;
      year_value    <= year_value_next;
      cursor        <= cursor_next;
    end
  end

  // Result register: valid is control state, the payload is loaded on every
  // accepted input transfer and held otherwise.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_second     <= to_bcd(second_value_next);
      out_minute     <= to_bcd(minute_value_next);
      out_hour       <= to_bcd(hour_value_next);
      out_weekday    <= to_bcd(weekday_value_next);
      out_date       <= to_bcd(date_value_next);
      out_month      <= to_bcd(month_value_next);
      out_year       <= to_bcd(year_value_next);
      selected_field <= cursor_next;
      committed      <= commit_next;
    end
  end

  // Every accepted event leaves a result behind it.
  assert property (@(posedge clk) disable iff (rst) in_fire |=> out_valid)
    else $error("accepted event produced no result");

  // A commit always comes with the cursor back on the hour field.
  assert property (@(posedge clk) disable iff (rst)
                   out_valid && committed |-> selected_field == FLD_HOUR)
    else $error("commit reported without cursor wrap");

  // A load never moves the cursor and never commits.
  assert property (@(posedge clk) disable iff (rst)
                   in_fire && opcode == OP_LOAD |=>
                   !committed && selected_field == $past(cursor))
    else $error("load disturbed cursor or commit");

  // The cursor never reaches the unused code.
  assert property (@(posedge clk) disable iff (rst) cursor <= FLD_WEEKDAY)
    else $error("cursor out of range");

endmodule

/* tb/tb.sv */
// Self-checking bench for the clock and calendar field editor.
//
// The sender side pushes load and button transfers into the block through
// plain tasks, and every accepted input transfer is handed to a small
// scoreboard. The scoreboard keeps its own copy of the seven calendar fields
// and the cursor, works out the packed-BCD result each transfer should give,
// and queues it. The receiver side checks every accepted result transfer
// against the oldest queued expectation, field by field.
module tb;

  import ccfe_pkg::*;

  // One expected or observed result transfer.
  typedef struct packed {
    value_t     second;
    value_t     minute;
    value_t     hour;
    value_t     weekday;
    value_t     date;
    value_t     month;
    value_t     year;
    field_sel_t cursor;
    logic       commit;
  } calendar_result_t;

  // Predicts the editor's results and compares them with what comes out.
  class calendar_scoreboard;
    value_t           second_v, minute_v, hour_v, weekday_v;
    value_t           date_v, month_v, year_v;
    field_sel_t       cursor_v;
    calendar_result_t awaited[$];
    int               mismatches;
    int               strays;

    function new();
      second_v = '0; minute_v = '0; hour_v = '0; weekday_v = '0;
      date_v = '0; month_v = '0; year_v = '0;
      cursor_v = FLD_HOUR;
      mismatches = 0;
      strays = 0;
    endfunction

    function value_t bcd_encode(value_t v);
      int tens;
      tens = v / 10;
      return value_t'((tens << 4) | (v % 10));
    endfunction

    function value_t bcd_decode(value_t b);
      return value_t'(b[7:4] * 10 + b[3:0]);
    endfunction

    function value_t step_up(value_t v, value_t top, value_t bottom);
      value_t n;
      n = v + 8'd1;
      return (n > top) ? bottom : n;
    endfunction

    // Hour, date, month and weekday treat anything at or below one as the
    // bottom; minute, second and year only wrap from exactly zero.
    function value_t step_down(value_t v, value_t top, bit from_one);
      if (from_one ? (v <= 8'd1) : (v == 8'd0))
        return top;
      return v - 8'd1;
    endfunction

    function value_t date_top();
      if (month_v == 8'd4 || month_v == 8'd6 || month_v == 8'd9 || month_v == 8'd11)
        return DATE_TOP_SHORT;
      return DATE_TOP;
    endfunction

    function int pending();
      return awaited.size();
    endfunction

    function int failures();
      return mismatches + strays;
    endfunction

    // Advances the copy of the editor by one accepted input transfer.
    function void note_input(opcode_t op, value_t ls, value_t lm, value_t lh,
                             value_t lw, value_t ld, value_t lmo, value_t ly);
      calendar_result_t r;
      logic             commit;
      commit = 1'b0;
      case (op)
        OP_LOAD: begin
          second_v  = bcd_decode(ls);
          minute_v  = bcd_decode(lm);
          hour_v    = bcd_decode(lh & HOUR_MASK);
          weekday_v = bcd_decode(lw);
          date_v    = bcd_decode(ld);
          month_v   = bcd_decode(lmo);
          year_v    = bcd_decode(ly);
        end
        OP_UP: begin
          case (cursor_v)
            FLD_HOUR:    hour_v    = step_up(hour_v, HOUR_TOP, 8'd1);
            FLD_MINUTE:  minute_v  = step_up(minute_v, MINSEC_TOP, 8'd0);
            FLD_SECOND:  second_v  = step_up(second_v, MINSEC_TOP, 8'd0);
            FLD_DATE:    date_v    = step_up(date_v, date_top(), 8'd1);
            FLD_MONTH:   month_v   = step_up(month_v, MONTH_TOP, 8'd1);
            FLD_YEAR:    year_v    = step_up(year_v, YEAR_TOP, 8'd0);
            FLD_WEEKDAY: weekday_v = step_up(weekday_v, WEEKDAY_TOP, 8'd1);
            default: ;
          endcase
        end
        OP_DOWN: begin
          case (cursor_v)
            FLD_HOUR:    hour_v    = step_down(hour_v, HOUR_TOP, 1'b1);
            FLD_MINUTE:  minute_v  = step_down(minute_v, MINSEC_TOP, 1'b0);
            FLD_SECOND:  second_v  = step_down(second_v, MINSEC_TOP, 1'b0);
            FLD_DATE:    date_v    = step_down(date_v, date_top(), 1'b1);
            FLD_MONTH:   month_v   = step_down(month_v, MONTH_TOP, 1'b1);
            FLD_YEAR:    year_v    = step_down(year_v, YEAR_TOP, 1'b0);
            FLD_WEEKDAY: weekday_v = step_down(weekday_v, WEEKDAY_TOP, 1'b1);
            default: ;
          endcase
        end
        default: begin
          if (cursor_v >= FLD_WEEKDAY) begin
            cursor_v = FLD_HOUR;
            commit   = 1'b1;
          end else begin
            cursor_v = cursor_v + 3'd1;
          end
        end
      endcase
      r.second  = bcd_encode(second_v);
      r.minute  = bcd_encode(minute_v);
      r.hour    = bcd_encode(hour_v);
      r.weekday = bcd_encode(weekday_v);
      r.date    = bcd_encode(date_v);
      r.month   = bcd_encode(month_v);
      r.year    = bcd_encode(year_v);
      r.cursor  = cursor_v;
      r.commit  = commit;
      awaited.push_back(r);
    endfunction

    function void compare(string name, logic [7:0] want, logic [7:0] seen);
      if (want !== seen) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: %s differs, expected %h, got %h", $time, name, want, seen);
      end
    endfunction

    function void check_result(calendar_result_t got);
      calendar_result_t want;
      if (awaited.size() == 0) begin
        strays++;
        $display("%0t: result transfer arrived with nothing outstanding", $time);
        return;
      end
      want = awaited.pop_front();
      compare("out_second", want.second, got.second);
      compare("out_minute", want.minute, got.minute);
      compare("out_hour", want.hour, got.hour);
      compare("out_weekday", want.weekday, got.weekday);
      compare("out_date", want.date, got.date);
      compare("out_month", want.month, got.month);
      compare("out_year", want.year, got.year);
      compare("selected_field", 8'(want.cursor), 8'(got.cursor));
      compare("committed", 8'(want.commit), 8'(got.commit));
    endfunction
  endclass

  // A run is declared hung once this many cycles pass with no transfer on
  // either channel. The slowest legitimate stretch is the largest sender
  // gap plus the largest receiver stall, so this leaves a wide margin.
  localparam int HANG_LIMIT     = 2000;
  localparam int RANDOM_ITEMS   = 1300;
  localparam int SETTLE_CYCLES  = 10;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_ready;
  opcode_t    opcode = OP_LOAD;
  value_t     load_second = '0;
  value_t     load_minute = '0;
  value_t     load_hour = '0;
  value_t     load_weekday = '0;
  value_t     load_date = '0;
  value_t     load_month = '0;
  value_t     load_year = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  value_t     out_second, out_minute, out_hour, out_weekday;
  value_t     out_date, out_month, out_year;
  field_sel_t selected_field;
  logic       committed;

  calendar_scoreboard sb;

  // Upper bounds on the per-transfer idle draws. They are changed from one
  // stretch of stimulus to the next so that back-to-back streams, light
  // idling and heavy idling all get their turn on both sides.
  int tx_max = 10;
  int rx_max = 10;
  int rx_wait = 0;
  int quiet_cycles = 0;

  clock_calendar_field_editor_top uut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .opcode         (opcode),
    .load_second    (load_second),
    .load_minute    (load_minute),
    .load_hour      (load_hour),
    .load_weekday   (load_weekday),
    .load_date      (load_date),
    .load_month     (load_month),
    .load_year      (load_year),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_second     (out_second),
    .out_minute     (out_minute),
    .out_hour       (out_hour),
    .out_weekday    (out_weekday),
    .out_date       (out_date),
    .out_month      (out_month),
    .out_year       (out_year),
    .selected_field (selected_field),
    .committed      (committed)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Sends one input transfer. The idle gap is drawn first; valid is only
  // lowered when there really is a gap, so a back-to-back transfer keeps
  // valid high without a drop inside the same time step. Inputs change on
  // the falling edge, and acceptance is judged at the rising edge.
  task automatic send_item(input opcode_t op, input value_t ls, input value_t lm,
                           input value_t lh, input value_t lw, input value_t ld,
                           input value_t lmo, input value_t ly);
    int gap;
    gap = $urandom_range(0, tx_max);
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    opcode       <= op;
    load_second  <= ls;
    load_minute  <= lm;
    load_hour    <= lh;
    load_weekday <= lw;
    load_date    <= ld;
    load_month   <= lmo;
    load_year    <= ly;
    in_valid     <= 1'b1;
    do @(posedge clk); while (!in_ready);
    sb.note_input(op, ls, lm, lh, lw, ld, lmo, ly);
  endtask

  // Button transfers carry random load bytes, which the block must ignore.
  task automatic send_button(input opcode_t op);
    send_item(op, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
              8'($urandom), 8'($urandom), 8'($urandom));
  endtask

  // Holds the sender off until every outstanding result has been taken.
  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // Draws a value within a field's legal range, leaning on the two ends so
  // that the wrap-around paths are exercised often.
  function automatic value_t range_value(int lo, int hi);
    case ($urandom_range(0, 3))
      0:       return value_t'(lo);
      1:       return value_t'(hi);
      default: return value_t'($urandom_range(lo, hi));
    endcase
  endfunction

  task automatic run_directed();
    // All bytes at their maximum: the hour mask leaves 0x1F, which decodes
    // to 25, and the other fields decode to 165, whose BCD form no longer
    // fits in a byte. Stepping the out-of-range hour up falls back to one.
    send_item(OP_LOAD, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
    send_button(OP_UP);
    // All zero: stepping the hour down from below its range goes to twelve.
    send_item(OP_LOAD, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
    send_button(OP_DOWN);
    // Every field at the top of its range, with junk in the hour's upper
    // three bits, which the mask must strip.
    send_item(OP_LOAD, 8'h59, 8'h59, 8'hF2, 8'h07, 8'h31, 8'h12, 8'h99);
    send_button(OP_UP);
    // Walk the cursor through the remaining fields, stepping each one up
    // and then down; all but the month start at the top and wrap both ways.
    for (int f = 1; f <= 6; f++) begin
      send_button(OP_SELECT);
      send_button(OP_UP);
      send_button(OP_DOWN);
      if (f == 3) begin
        // A thirty-day month moves the top of the date range.
        send_item(OP_LOAD, 8'h59, 8'h59, 8'h12, 8'h07, 8'h01, 8'h04, 8'h99);
        send_button(OP_DOWN);
      end
    end
    // The seventh select returns the cursor to the hour and flags commit.
    send_button(OP_SELECT);
  endtask

  // Mostly button presses over well-formed calendar loads, so the cursor
  // wanders through every field with sensible values; a share of loads
  // carry arbitrary bytes to cover invalid digits and out-of-range values.
  task automatic random_item();
    int     pick;
    value_t hour_byte;
    pick = $urandom_range(0, 99);
    if (pick < 12) begin
      hour_byte = sb.bcd_encode(range_value(1, 12));
      if ($urandom_range(0, 1) == 1)
        hour_byte[7:5] = 3'($urandom);
      send_item(OP_LOAD, sb.bcd_encode(range_value(0, 59)),
                sb.bcd_encode(range_value(0, 59)), hour_byte,
                sb.bcd_encode(range_value(1, 7)), sb.bcd_encode(range_value(1, 31)),
                sb.bcd_encode(range_value(1, 12)), sb.bcd_encode(range_value(0, 99)));
    end else if (pick < 17) begin
      send_item(OP_LOAD, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                8'($urandom), 8'($urandom), 8'($urandom));
    end else if (pick < 45) begin
      send_button(OP_UP);
    end else if (pick < 73) begin
      send_button(OP_DOWN);
    end else begin
      send_button(OP_SELECT);
    end
  endtask

  function automatic int idle_bound();
    case ($urandom_range(0, 2))
      0:       return 0;
      1:       return 3;
      default: return 10;
    endcase
  endfunction

  // Receiver: after each result transfer it draws how long to hold ready
  // low. Results are sampled at the rising edge, ready moves on the falling
  // edge.
  always @(posedge clk) begin
    calendar_result_t got;
    if (!rst) begin
      if (out_valid && out_ready) begin
        got.second  = out_second;
        got.minute  = out_minute;
        got.hour    = out_hour;
        got.weekday = out_weekday;
        got.date    = out_date;
        got.month   = out_month;
        got.year    = out_year;
        got.cursor  = selected_field;
        got.commit  = committed;
        sb.check_result(got);
        rx_wait = $urandom_range(0, rx_max);
      end else if (rx_wait > 0) begin
        rx_wait--;
      end
    end
  end

  always @(negedge clk) begin
    out_ready <= !rst && (rx_wait == 0);
  end

  // Watchdog on transfers of either kind.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= HANG_LIMIT) begin
        $display("%0t: no transfer for %0d cycles", $time, HANG_LIMIT);
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  initial begin
    int sent;
    int stretch;
    int phase;
    sb = new();
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    run_directed();

    sent  = 0;
    phase = 0;
    while (sent < RANDOM_ITEMS) begin
      tx_max = idle_bound();
      rx_max = idle_bound();
      // The first stretch always starts from an empty pipeline; later ones
      // do so now and then.
      if (phase == 0 || $urandom_range(0, 3) == 0)
        drain_results();
      stretch = $urandom_range(20, 80);
      repeat (stretch) begin
        random_item();
        sent++;
      end
      phase++;
    end

    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (sb.failures() == 0 && sb.pending() == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
